// ===== sv/qmm_pkg.sv =====
// Package for the quad motor mixer: fixed-point constants, state codes and
// the sequencer-to-datapath control struct. No dependencies.
`default_nettype none
package qmm_pkg;
  localparam int FracBits = 14;
  localparam int NumMotors = 4;
  localparam logic signed [19:0] OneQ = 20'sd16384;
  localparam logic signed [19:0] HalfOneQ = 20'sd8192;
  localparam logic signed [19:0] StepSmall = 20'sd82;
  localparam logic signed [19:0] StepLarge = 20'sd164;
  localparam logic signed [19:0] TinyQ = 20'sd2;
  localparam logic signed [19:0] MilliQ = 20'sd16;
  localparam logic signed [19:0] TenthQ = 20'sd1638;

  localparam logic [2:0] REG_CURVE_A = 3'd0;
  localparam logic [2:0] REG_CURVE_B = 3'd1;
  localparam logic [2:0] REG_CURVE_C = 3'd2;
  localparam logic [2:0] REG_RED_MAX = 3'd3;
  localparam logic [2:0] REG_INC_MAX = 3'd4;
  localparam logic [2:0] REG_PERCENT = 3'd5;
  localparam logic [2:0] REG_MOTOR_MAX = 3'd6;
  localparam logic [2:0] REG_ENABLES = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MIX, ST_FILT, ST_SCALE_O, ST_SCALE_U, ST_CORR,
    ST_CLIP, ST_SQR, ST_POLY_A, ST_POLY_B, ST_FINISH, ST_DECAY_O, ST_DECAY_U, ST_OUT
  } qmm_state_t;

  // multiply operand selects for the shared multiplier
  typedef enum logic [2:0] {
    MUL_PCT_O, MUL_PCT_U, MUL_SQR, MUL_A, MUL_B, MUL_DEC_O, MUL_DEC_U
  } qmm_mop_t;

  typedef struct packed {
    logic     mul_go;
    qmm_mop_t mop;
    logic [1:0] motor;
  } qmm_ctrl_t;

  // round half away from zero of p/100 by reciprocal multiply, |p| below 2^22
  function automatic logic signed [19:0] div_round100(input logic signed [27:0] p);
    logic [27:0] mg;
    logic [51:0] q;
    mg = p[27] ? 28'(-p) : 28'(p);
    q = (52'(mg + 28'd50) * 52'd5368710) >> 29;
    return p[27] ? -20'(signed'(q[19:0])) : 20'(signed'(q[19:0]));
  endfunction
  // round half away from zero of p/25 by reciprocal multiply, |p| below 2^20
  function automatic logic signed [19:0] div_round25(input logic signed [27:0] p);
    logic [27:0] mg;
    logic [47:0] q;
    mg = p[27] ? 28'(-p) : 28'(p);
    q = (48'(mg + 28'd12) * 48'd671089) >> 24;
    return p[27] ? -20'(signed'(q[19:0])) : 20'(signed'(q[19:0]));
  endfunction
endpackage
`default_nettype wire

// ===== sv/qmm_mul.sv =====
// Shared registered signed multiplier, 20x20 -> 40 bits.
// Depends on qmm_pkg.
`default_nettype none
module qmm_mul import qmm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               go,
  input  wire logic signed [19:0] a,
  input  wire logic signed [19:0] b,
  output logic signed [39:0]      p_r
);
  logic signed [39:0] p_nxt;
  assign p_nxt = go ? a * b : p_r;
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/quad_motor_mixer_desaturate.sv =====
// Quad X motor mixer with desaturation filters, clip feedforward and thrust curve.
// Uses qmm_pkg and qmm_mul (the one shared multiplier).
// ---------------------------------------------------------------------------
// Usage: one item per control tick on in_* (tdata = throttle_stick, roll_out,
// pitch_out, yaw_out, motors_off from the low bit up). One result item leaves
// on out_* (four duties, thrust_average, saturated). Configuration writes go
// through cfg_we/cfg_addr/cfg_wdata; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Timing: a sequencer drives one shared 20x20 multiplier, one product per
// cycle, registered before use. With motors on and a correction bit set an
// item runs mix, filter, two percent scalings and correction, then per motor
// clip feedforward, square, b*x, a*x2 and curve sum, then an output step
// that writes the output register. A new item is taken only once the
// sequencer is back in idle. With both correction bits clear the scalings
// and correction are skipped. Motors off runs two decay multiplies.
// Reset: synchronous active-low rst_n restores register defaults, clears both
// filters and all clip carries, and empties the output register.
// Stall: the result waits in the output register while out_tready is low;
// the next item is still taken and computed, then held in its last step
// until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none
module quad_motor_mixer_desaturate import qmm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // throttle_stick[14:0], roll_out[31:15], pitch_out[48:32], yaw_out[65:49],
  // motors_off[66], zero fill
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // duty_fr[14:0], duty_fl[29:15], duty_br[44:30], duty_bl[59:45],
  // thrust_average[74:60], saturated[75], zero fill
  output logic [79:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  qmm_state_t st_r, st_nxt;
  logic [15:0] ca_r, cb_r, cc_r;
  logic [14:0] redmax_r, incmax_r, mmax_r;
  logic [6:0]  pct_r;
  logic [3:0]  en_r;
  logic signed [19:0] of_r, of_nxt, uf_r, uf_nxt;
  logic signed [19:0] carry_r [NumMotors];
  logic signed [19:0] carry_nxt;
  logic signed [19:0] mix_r [NumMotors];
  logic signed [19:0] mixk_nxt;
  logic signed [19:0] ov_r, ov_nxt, un_r, un_nxt;
  logic signed [19:0] x_r, x_nxt, x2_r;
  logic signed [39:0] bx_r;
  logic [16:0] sum_r, sum_nxt;
  logic [14:0] duty_r [NumMotors];
  logic [14:0] duty_nxt;
  logic sat_r, sat_nxt, off_r;
  logic [1:0] k_r, k_nxt;
  logic ovalid_r, ovalid_nxt;
  logic [79:0] odata_r, odata_nxt;
  qmm_ctrl_t ctrl;
  logic signed [19:0] ma, mb;
  logic signed [39:0] prod;

  qmm_mul u_mul (.clk(clk), .go(ctrl.mul_go), .a(ma), .b(mb), .p_r(prod));

  function automatic logic signed [19:0] clamp01(input logic signed [19:0] v);
    if (v < 0) return '0;
    if (v > OneQ) return OneQ;
    return v;
  endfunction
  function automatic logic signed [39:0] rshift(input logic signed [39:0] v);
    return (v + 40'(HalfOneQ)) >>> FracBits;
  endfunction

  // throttle map and X mix; divide by ten through a reciprocal multiply
  function automatic logic signed [19:0] mixf(input logic signed [19:0] xs,
      input logic signed [19:0] r, input logic signed [19:0] p,
      input logic signed [19:0] yy, input logic [1:0] k);
    logic signed [19:0] t, y;
    logic [39:0] q;
    t = 20'sd11 * xs - OneQ;
    q = (40'(unsigned'(t + 20'sd5)) * 40'd419431) >> 22;
    if (t <= 0) t = '0;
    else t = 20'(q);
    if (t > OneQ) t = OneQ;
    y = en_r[3] ? -yy : yy;
    case (k)
      2'd0: return t - r - p + y;
      2'd1: return t + r - p - y;
      2'd2: return t - r + p - y;
      default: return t + r + p + y;
    endcase
  endfunction

  // mux operands into the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl.mop)
      MUL_PCT_O: begin ma = ov_r; mb = 20'(pct_r > 7'd100 ? 7'd100 : pct_r); end
      MUL_PCT_U: begin ma = un_r; mb = 20'(pct_r > 7'd100 ? 7'd100 : pct_r); end
      MUL_SQR:   begin ma = x_r; mb = x_r; end
      MUL_A:     begin ma = x2_r; mb = 20'(signed'(ca_r)); end
      MUL_B:     begin ma = x_r; mb = 20'(signed'(cb_r)); end
      MUL_DEC_O: begin ma = of_r; mb = 20'sd18; end
      MUL_DEC_U: begin ma = uf_r; mb = 20'sd18; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    logic signed [19:0] mx, mn, o, u, m, c, diff, rmx, imx, mmx;
    logic signed [39:0] cur;
    st_nxt = st_r; of_nxt = of_r; uf_nxt = uf_r; ov_nxt = ov_r; un_nxt = un_r;
    x_nxt = x_r; sum_nxt = sum_r; sat_nxt = sat_r; k_nxt = k_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r; carry_nxt = carry_r[k_r];
    mixk_nxt = mix_r[k_r]; duty_nxt = duty_r[k_r];
    ctrl = '{mul_go: 1'b0, mop: MUL_SQR, motor: k_r};
    in_tready = (st_r == ST_IDLE);
    mx = '0; mn = '0; o = '0; u = '0; m = '0; c = '0; diff = '0; cur = '0;
    rmx = signed'(20'(redmax_r));
    imx = signed'(20'(incmax_r));
    mmx = signed'(20'(mmax_r));
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        k_nxt = '0; sum_nxt = '0; sat_nxt = 1'b0;
        if (in_tvalid && in_tready) st_nxt = in_tdata[66] ? ST_DECAY_O : ST_MIX;
      end
      ST_MIX: st_nxt = ST_FILT; // mixes are written in the clocked block
      ST_FILT: begin
        if (en_r[1:0] == 2'b00) begin
          // no correction: hold both filters and skip the scalings
          sat_nxt = 1'b0;
          st_nxt = ST_CLIP;
        end else begin
          mx = '0; mn = MilliQ;
          for (int i = 0; i < NumMotors; i++) begin
            if (mix_r[i] > mx) mx = mix_r[i];
            if (mix_r[i] < mn) mn = mix_r[i];
          end
          o = mx - mmx;
          if (o > rmx) o = rmx;
          of_nxt = (o > of_r) ? of_r + StepSmall : of_r - StepLarge;
          if (of_nxt > rmx) of_nxt = rmx;
          if (of_nxt < -TenthQ) of_nxt = -TenthQ;
          ov_nxt = of_nxt < 0 ? -TinyQ : of_nxt;
          if (en_r[1]) begin
            u = mn;
            if (u < -imx) u = -imx;
            uf_nxt = (u < uf_r) ? uf_r - StepSmall : uf_r + StepLarge;
            if (uf_nxt < -rmx) uf_nxt = -rmx;
            if (uf_nxt > TenthQ) uf_nxt = TenthQ;
            un_nxt = uf_nxt > 0 ? TinyQ : uf_nxt;
          end
          st_nxt = ST_SCALE_O;
        end
      end
      ST_SCALE_O: begin ctrl.mul_go = 1'b1; ctrl.mop = MUL_PCT_O; st_nxt = ST_SCALE_U; end
      ST_SCALE_U: begin
        ov_nxt = en_r[0] ? div_round100(prod[27:0]) : -TinyQ;
        ctrl.mul_go = 1'b1; ctrl.mop = MUL_PCT_U; st_nxt = ST_CORR;
      end
      ST_CORR: begin
        un_nxt = en_r[1] ? div_round100(prod[27:0]) : MilliQ;
        sat_nxt = (ov_r > 0) || (un_nxt < 0);
        st_nxt = ST_CLIP;
      end
      ST_CLIP: begin
        m = mix_r[k_r];
        if (sat_r) m = m - (ov_r + un_r);
        c = carry_r[k_r];
        if (en_r[2]) begin
          if (m > OneQ) begin
            c = c + m - OneQ;
            if (c > HalfOneQ) c = HalfOneQ;
          end else if (c > 0) begin
            diff = OneQ - m;
            m = m + c;
            if (m > OneQ) begin
              c = c - diff;
              if (c < 0) c = '0;
            end else c = '0;
          end
        end
        carry_nxt = c; mixk_nxt = m;
        x_nxt = clamp01(m);
        sum_nxt = sum_r + 17'(clamp01(m));
        st_nxt = ST_SQR;
      end
      ST_SQR: begin ctrl.mul_go = 1'b1; ctrl.mop = MUL_SQR; st_nxt = ST_POLY_A; end
      ST_POLY_A: begin
        ctrl.mul_go = 1'b1; ctrl.mop = MUL_B; st_nxt = ST_POLY_B;
      end
      ST_POLY_B: begin
        ctrl.mul_go = 1'b1; ctrl.mop = MUL_A; st_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cur = rshift(bx_r + prod) + 40'(signed'(cc_r));
        if (cur < 0) duty_nxt = '0;
        else if (cur > 40'(OneQ)) duty_nxt = 15'(OneQ);
        else duty_nxt = cur[14:0];
        k_nxt = k_r + 2'd1;
        st_nxt = (k_r == 2'(NumMotors - 1)) ? ST_OUT : ST_CLIP;
      end
      ST_DECAY_O: begin ctrl.mul_go = 1'b1; ctrl.mop = MUL_DEC_O; st_nxt = ST_DECAY_U; end
      ST_DECAY_U: begin
        of_nxt = div_round25(prod[27:0]);
        ctrl.mul_go = 1'b1; ctrl.mop = MUL_DEC_U; st_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold here while the previous result still waits
        if (!ovalid_r || out_tready) begin
          if (off_r) begin
            uf_nxt = div_round25(prod[27:0]);
            odata_nxt = '0;
          end else begin
            odata_nxt = {4'd0, sat_r, 15'((sum_r + 17'd2) >> 2),
                         duty_r[3], duty_r[2], duty_r[1], duty_r[0]};
          end
          ovalid_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // input, mix, clip capture; curve: x2 after the square, b*x before a*x2 arrives
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: if (in_tvalid && in_tready) begin
        off_r <= in_tdata[66];
        x_r <= 20'(in_tdata[14:0]);
        mix_r[0] <= 20'(signed'(in_tdata[31:15]));
        mix_r[1] <= 20'(signed'(in_tdata[48:32]));
        mix_r[2] <= 20'(signed'(in_tdata[65:49]));
      end
      ST_MIX: begin
        // x_r holds the stick, mix_r[0..2] hold roll, pitch, yaw
        mix_r[0] <= mixf(x_r, mix_r[0], mix_r[1], mix_r[2], 2'd0);
        mix_r[1] <= mixf(x_r, mix_r[0], mix_r[1], mix_r[2], 2'd1);
        mix_r[2] <= mixf(x_r, mix_r[0], mix_r[1], mix_r[2], 2'd2);
        mix_r[3] <= mixf(x_r, mix_r[0], mix_r[1], mix_r[2], 2'd3);
      end
      ST_CLIP: mix_r[k_r] <= mixk_nxt;
      ST_POLY_A: x2_r <= 20'(rshift(prod));
      ST_POLY_B: bx_r <= prod;
      default: ;
    endcase
    if (st_r == ST_FINISH) duty_r[k_r] <= duty_nxt;
    ov_r <= ov_nxt; un_r <= un_nxt;
    if (st_r != ST_IDLE && st_r != ST_MIX) x_r <= x_nxt;
    odata_r <= odata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ovalid_r <= 1'b0; of_r <= '0; uf_r <= '0;
      for (int i = 0; i < NumMotors; i++) carry_r[i] <= '0;
      ca_r <= 16'd4293; cb_r <= 16'd12632; cc_r <= 16'hFE59;
      redmax_r <= 15'd8192; incmax_r <= 15'd3277; pct_r <= 7'd100;
      mmax_r <= 15'd16384; en_r <= 4'hF; k_r <= '0; sum_r <= '0; sat_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ovalid_r <= ovalid_nxt; k_r <= k_nxt;
      sat_r <= sat_nxt; sum_r <= sum_nxt;
      of_r <= of_nxt; uf_r <= uf_nxt;
      if (st_r == ST_CLIP) carry_r[k_r] <= carry_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CURVE_A: ca_r <= cfg_wdata;
          REG_CURVE_B: cb_r <= cfg_wdata;
          REG_CURVE_C: cc_r <= cfg_wdata;
          REG_RED_MAX: redmax_r <= cfg_wdata[14:0];
          REG_INC_MAX: incmax_r <= cfg_wdata[14:0];
          REG_PERCENT: pct_r <= cfg_wdata[6:0];
          REG_MOTOR_MAX: mmax_r <= cfg_wdata[14:0];
          REG_ENABLES: en_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
endmodule
`default_nettype wire

// ===== sv/qmm_checker.sv =====
// Port-level checker for quad_motor_mixer_desaturate, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none
module qmm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result present after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= 15'd16384) else $error("duty range");
endmodule
bind quad_motor_mixer_desaturate qmm_checker u_chk (.*);
`default_nettype wire
